[hdl/ascon_pkg.sv]
`default_nettype none
package ascon_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned RND_IDX_W  = 4;

  localparam logic [WORD_W-1:0] IV_RESET = 64'h80400c0600000000;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  // register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_KEY_FIRST    = 3'd0,
    REG_KEY_SECOND   = 3'd1,
    REG_NONCE_FIRST  = 3'd2,
    REG_NONCE_SECOND = 3'd3,
    REG_INIT_VECTOR  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] key_first;
    logic [WORD_W-1:0] key_second;
    logic [WORD_W-1:0] nonce_first;
    logic [WORD_W-1:0] nonce_second;
    logic [WORD_W-1:0] init_vector;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic                 in_ready;
    logic                 load_init;
    logic                 round;
    logic [RND_IDX_W-1:0] rc_idx;
    logic                 key_init;
    logic                 absorb;
    logic                 emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_first;
    logic in_last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] round_const(input logic [RND_IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'hf0;
      4'd1:    c = 8'he1;
      4'd2:    c = 8'hd2;
      4'd3:    c = 8'hc3;
      4'd4:    c = 8'hb4;
      4'd5:    c = 8'ha5;
      4'd6:    c = 8'h96;
      4'd7:    c = 8'h87;
      4'd8:    c = 8'h78;
      4'd9:    c = 8'h69;
      4'd10:   c = 8'h5a;
      4'd11:   c = 8'h4b;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                             input int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  // one permutation round: constant addition, S-box layer, linear layer
  function automatic state_t ascon_round(input state_t s, input logic [7:0] c);
    logic [WORD_W-1:0] x0, x1, x2, x3, x4, n0, n1, n2, n3, n4;
    state_t r;
    x0 = s[0];
    x1 = s[1];
    x2 = s[2] ^ {{(WORD_W-8){1'b0}}, c};
    x3 = s[3];
    x4 = s[4];
    x0 = x0 ^ x4;
    x4 = x4 ^ x3;
    x2 = x2 ^ x1;
    n0 = ~x0 & x1;
    n1 = ~x1 & x2;
    n2 = ~x2 & x3;
    n3 = ~x3 & x4;
    n4 = ~x4 & x0;
    x0 = x0 ^ n1;
    x1 = x1 ^ n2;
    x2 = x2 ^ n3;
    x3 = x3 ^ n4;
    x4 = x4 ^ n0;
    x1 = x1 ^ x0;
    x0 = x0 ^ x4;
    x3 = x3 ^ x2;
    x2 = ~x2;
    r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
    r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
    r[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
    r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
    r[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/ascon_in_if.sv]
`default_nettype none
interface ascon_in_if;
  import ascon_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] plaintext_word;
  logic              first_block;
  logic              last_block;

  modport source (output valid, output plaintext_word, output first_block,
                  output last_block, input ready);
  modport sink   (input valid, input plaintext_word, input first_block,
                  input last_block, output ready);
endinterface
`default_nettype wire

[hdl/ascon_out_if.sv]
`default_nettype none
interface ascon_out_if;
  import ascon_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] ciphertext_word;
  logic              tag_valid;
  logic [WORD_W-1:0] tag_first;
  logic [WORD_W-1:0] tag_second;

  modport source (output valid, output ciphertext_word, output tag_valid,
                  output tag_first, output tag_second, input ready);
  modport sink   (input valid, input ciphertext_word, input tag_valid,
                  input tag_first, input tag_second, output ready);
endinterface
`default_nettype wire

[hdl/ascon128_encrypt_stream_top.sv]
`default_nettype none
// Ascon-128 stream encryption, one 64-bit word per item, one round per cycle.
// Middle word: accept, absorb, 6 rounds, result load. The first word adds
// 12 rounds and a key step; the last word runs 12 rounds instead of 6.
// Reset (rst_n low, synchronous): controller idle, no open message, output
// empty, key and nonce registers zero, IV register 0x80400c0600000000.
module ascon128_encrypt_stream_top (
  input  wire                              clk,
  input  wire                              rst_n,
  ascon_in_if.sink                         in_chan,
  ascon_out_if.source                      out_chan,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [ascon_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire  [ascon_pkg::WORD_W-1:0]     pwdata,
  output logic [ascon_pkg::WORD_W-1:0]     prdata,
  output logic                             pready
);
  import ascon_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  // Register file: 64-bit registers at byte address 8*index.
  ascon_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: init rounds, key step, absorb, block or final rounds, result load.
  // It also tracks whether a message is open; a word with no open message
  // starts one just like a first word.
  ascon_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  // Datapath: five-word state, shared round unit, output register. The
  // output register lets a result wait while the next word is worked on.
  ascon_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .st       (st),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

[hdl/ascon_cfg.sv]
`default_nettype none
module ascon_cfg (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [ascon_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire  [ascon_pkg::WORD_W-1:0]     pwdata,
  output logic [ascon_pkg::WORD_W-1:0]     prdata,
  output logic                             pready,
  output ascon_pkg::cfg_t                  cfg
);
  import ascon_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_first    <= '0;
      cfg_r.key_second   <= '0;
      cfg_r.nonce_first  <= '0;
      cfg_r.nonce_second <= '0;
      cfg_r.init_vector  <= IV_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_FIRST:    cfg_r.key_first    <= pwdata;
        REG_KEY_SECOND:   cfg_r.key_second   <= pwdata;
        REG_NONCE_FIRST:  cfg_r.nonce_first  <= pwdata;
        REG_NONCE_SECOND: cfg_r.nonce_second <= pwdata;
        REG_INIT_VECTOR:  cfg_r.init_vector  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_FIRST:    prdata = cfg_r.key_first;
      REG_KEY_SECOND:   prdata = cfg_r.key_second;
      REG_NONCE_FIRST:  prdata = cfg_r.nonce_first;
      REG_NONCE_SECOND: prdata = cfg_r.nonce_second;
      REG_INIT_VECTOR:  prdata = cfg_r.init_vector;
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[hdl/ascon_ctrl.sv]
`default_nettype none
module ascon_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ascon_pkg::status_t   st,
  output ascon_pkg::cmd_t      cmd
);
  import ascon_pkg::*;

  localparam logic [RND_IDX_W-1:0] LAST_RND = RND_IDX_W'(11);
  localparam logic [RND_IDX_W-1:0] PB_START = RND_IDX_W'(6);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_RND,
    S_INIT_KEY,
    S_ABSORB,
    S_RND,
    S_EMIT
  } ctrl_state_t;

  ctrl_state_t          state_r, state_nxt;
  logic [RND_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                 in_msg_r, in_msg_nxt;
  logic                 last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      in_msg_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      in_msg_r <= in_msg_nxt;
      last_r   <= last_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    in_msg_nxt = in_msg_r;
    last_nxt   = last_r;
    cmd.rc_idx = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          last_nxt = st.in_last;
          if (st.in_first || !in_msg_r) begin
            cmd.load_init = 1'b1;
            in_msg_nxt    = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = S_INIT_RND;
          end else begin
            state_nxt = S_ABSORB;
          end
        end
      end
      S_INIT_RND: begin
        cmd.round = 1'b1;
        if (cnt_r == LAST_RND) begin
          state_nxt = S_INIT_KEY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_INIT_KEY: begin
        cmd.key_init = 1'b1;
        state_nxt    = S_ABSORB;
      end
      S_ABSORB: begin
        cmd.absorb = 1'b1;
        cnt_nxt    = last_r ? '0 : PB_START;
        state_nxt  = S_RND;
      end
      S_RND: begin
        cmd.round = 1'b1;
        if (cnt_r == LAST_RND) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
          if (last_r) begin
            in_msg_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hdl/ascon_dp.sv]
`default_nettype none
module ascon_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ascon_pkg::cfg_t      cfg,
  input  ascon_pkg::cmd_t      cmd,
  output ascon_pkg::status_t   st,
  ascon_in_if.sink             in_chan,
  ascon_out_if.source          out_chan
);
  import ascon_pkg::*;

  state_t            s_r;
  logic [WORD_W-1:0] pt_r;
  logic              last_r;
  logic [WORD_W-1:0] ct_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_ct_r, out_tag0_r, out_tag1_r;
  logic              out_tagv_r;
  logic              in_acc;
  logic [WORD_W-1:0] ct_new;
  state_t            rnd_out;

  assign in_chan.ready = cmd.in_ready;
  assign in_acc        = in_chan.valid & cmd.in_ready;
  assign ct_new        = pt_r ^ s_r[0];
  assign rnd_out       = ascon_round(s_r, round_const(cmd.rc_idx));

  assign st.in_valid = in_chan.valid;
  assign st.in_first = in_chan.first_block;
  assign st.in_last  = in_chan.last_block;
  assign st.out_free = ~out_valid_r | out_chan.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt_r   <= in_chan.plaintext_word;
      last_r <= in_chan.last_block;
    end
    if (cmd.load_init) begin
      s_r <= {cfg.nonce_second, cfg.nonce_first, cfg.key_second,
              cfg.key_first, cfg.init_vector};
    end else if (cmd.round) begin
      s_r <= rnd_out;
    end else if (cmd.key_init) begin
      s_r[3] <= s_r[3] ^ cfg.key_first;
      s_r[4] <= s_r[4] ^ cfg.key_second ^ {{(WORD_W-1){1'b0}}, 1'b1};
    end else if (cmd.absorb) begin
      s_r[0] <= ct_new;
      ct_r   <= ct_new;
      if (last_r) begin
        s_r[1] <= s_r[1] ^ cfg.key_first;
        s_r[2] <= s_r[2] ^ cfg.key_second;
      end
    end
    if (cmd.emit) begin
      out_ct_r   <= ct_r;
      out_tagv_r <= last_r;
      out_tag0_r <= last_r ? (s_r[3] ^ cfg.key_first)  : '0;
      out_tag1_r <= last_r ? (s_r[4] ^ cfg.key_second) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.ciphertext_word = out_ct_r;
  assign out_chan.tag_valid       = out_tagv_r;
  assign out_chan.tag_first       = out_tag0_r;
  assign out_chan.tag_second      = out_tag1_r;

endmodule
`default_nettype wire

[bench/tb.sv]
module tb;
  import ascon_pkg::*;

  // Kinds of row in the directed plan: a word to encrypt, or a register write.
  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    reg_idx_t          sel;
    logic [WORD_W-1:0] data;       // plaintext for a word row, value for a write
    logic              first;
    logic              last;
    logic              tag_clear;  // tag fields typed in as zero
  } plan_row_t;

  // One result word as the block should return it.
  typedef struct packed {
    logic [WORD_W-1:0] ciphertext;
    logic              tag_valid;
    logic [WORD_W-1:0] tag_first;
    logic [WORD_W-1:0] tag_second;
  } cipher_out_t;

  localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] ZERO = {WORD_W{1'b0}};
  localparam int PLAN_LEN = 32;
  localparam int RANDOM_WORDS = 600;
  // Wait after the final drain; leave margin for a stray word.
  localparam int SETTLE_CYCLES = 40;

  // Directed plan. Tag fields are typed in where the word is not the last
  // one; everything else comes from the encryption predictor.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // default registers after reset
    '{ROW_WORD, REG_KEY_FIRST, ZERO, 1'b0, 1'b0, 1'b1},    // no open message: opens one
    '{ROW_WORD, REG_KEY_FIRST, ONES, 1'b0, 1'b0, 1'b1},
    '{ROW_WORD, REG_KEY_FIRST, 64'h8000000000000000, 1'b0, 1'b1, 1'b0},
    '{ROW_WORD, REG_KEY_FIRST, ONES, 1'b1, 1'b1, 1'b0},    // one-word message
    '{ROW_WORD, REG_KEY_FIRST, ZERO, 1'b0, 1'b1, 1'b0},    // last with no open message
    '{ROW_WORD, REG_KEY_FIRST, 64'h5555555555555555, 1'b1, 1'b0, 1'b1},
    '{ROW_WORD, REG_KEY_FIRST, 64'haaaaaaaaaaaaaaaa, 1'b1, 1'b0, 1'b1}, // abandon open one
    '{ROW_WORD, REG_KEY_FIRST, 64'h0123456789abcdef, 1'b0, 1'b1, 1'b0},
    // every register at all ones
    '{ROW_CFG, REG_KEY_FIRST, ONES, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_KEY_SECOND, ONES, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_NONCE_FIRST, ONES, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_NONCE_SECOND, ONES, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_INIT_VECTOR, ONES, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_KEY_FIRST, ZERO, 1'b1, 1'b0, 1'b1},
    '{ROW_WORD, REG_KEY_FIRST, ONES, 1'b0, 1'b0, 1'b1},
    '{ROW_WORD, REG_KEY_FIRST, ZERO, 1'b0, 1'b1, 1'b0},
    '{ROW_WORD, REG_KEY_FIRST, ONES, 1'b1, 1'b1, 1'b0},
    // every register at zero
    '{ROW_CFG, REG_INIT_VECTOR, ZERO, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_KEY_FIRST, ZERO, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_KEY_SECOND, ZERO, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_NONCE_FIRST, ZERO, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_NONCE_SECOND, ZERO, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_KEY_FIRST, ZERO, 1'b1, 1'b1, 1'b0},
    // writes in the middle of an open message
    '{ROW_WORD, REG_KEY_FIRST, 64'h0f1e2d3c4b5a6978, 1'b1, 1'b0, 1'b1},
    '{ROW_CFG, REG_KEY_FIRST, 64'h0123456789abcdef, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_NONCE_FIRST, 64'hfedcba9876543210, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG, REG_INIT_VECTOR, IV_RESET, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_KEY_FIRST, 64'h1111111111111111, 1'b0, 1'b0, 1'b1},
    '{ROW_CFG, REG_KEY_SECOND, 64'h8000000000000001, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_KEY_FIRST, 64'h2222222222222222, 1'b0, 1'b1, 1'b0}, // new key in tag
    '{ROW_WORD, REG_KEY_FIRST, 64'h3333333333333333, 1'b0, 1'b0, 1'b1}, // new registers
    '{ROW_WORD, REG_KEY_FIRST, 64'h4444444444444444, 1'b0, 1'b1, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [WORD_W-1:0]     pwdata;
  logic [WORD_W-1:0]     prdata;
  logic                  pready;

  ascon_in_if  in_if ();
  ascon_out_if out_if ();

  ascon128_encrypt_stream_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: the five lanes of the cipher, the open-message flag and
  // a mirror of the registers as the block should hold them.
  logic [WORD_W-1:0] lane [NUM_WORDS];
  logic              msg_open;
  cfg_t              cfg_mirror;

  cipher_out_t ciphertext_due [$];
  int          mismatch_count;
  int          words_sent;
  logic        burst_mode;  // both sides stop idling while this is set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  function automatic logic [WORD_W-1:0] ror64(input logic [WORD_W-1:0] v, input int n);
    logic [2*WORD_W-1:0] both;
    both = {v, v} >> n;
    return both[WORD_W-1:0];
  endfunction

  // Apply the last n rounds of the twelve-round schedule to the lanes.
  function automatic void run_rounds(input int n);
    logic [WORD_W-1:0] a, b, c, d, e, t0, t1, t2, t3, t4;
    logic [3:0]        lo;
    int                idx;
    for (int r = 0; r < n; r++) begin
      idx = 12 - n + r;
      lo  = idx[3:0];
      // round constants step down by 0x0f from 0xf0
      a = lane[0];
      b = lane[1];
      c = lane[2] ^ {{(WORD_W-8){1'b0}}, 4'd15 - lo, lo};
      d = lane[3];
      e = lane[4];
      a = a ^ e;
      e = e ^ d;
      c = c ^ b;
      t0 = ~a & b;
      t1 = ~b & c;
      t2 = ~c & d;
      t3 = ~d & e;
      t4 = ~e & a;
      a = a ^ t1;
      b = b ^ t2;
      c = c ^ t3;
      d = d ^ t4;
      e = e ^ t0;
      b = b ^ a;
      a = a ^ e;
      d = d ^ c;
      c = ~c;
      lane[0] = a ^ ror64(a, 19) ^ ror64(a, 28);
      lane[1] = b ^ ror64(b, 61) ^ ror64(b, 39);
      lane[2] = c ^ ror64(c, 1) ^ ror64(c, 6);
      lane[3] = d ^ ror64(d, 10) ^ ror64(d, 17);
      lane[4] = e ^ ror64(e, 7) ^ ror64(e, 41);
    end
  endfunction

  // Encrypt one accepted word and advance the predictor state.
  function automatic cipher_out_t encrypt_word(input logic [WORD_W-1:0] pt,
                                               input logic first, input logic last);
    cipher_out_t res;
    if (first || !msg_open) begin
      lane[0] = cfg_mirror.init_vector;
      lane[1] = cfg_mirror.key_first;
      lane[2] = cfg_mirror.key_second;
      lane[3] = cfg_mirror.nonce_first;
      lane[4] = cfg_mirror.nonce_second;
      run_rounds(12);
      lane[3] = lane[3] ^ cfg_mirror.key_first;
      // key plus the domain-separation bit, no associated data
      lane[4] = lane[4] ^ cfg_mirror.key_second ^ {{(WORD_W-1){1'b0}}, 1'b1};
      msg_open = 1'b1;
    end
    res.ciphertext = pt ^ lane[0];
    lane[0] = res.ciphertext;
    if (last) begin
      lane[1] = lane[1] ^ cfg_mirror.key_first;
      lane[2] = lane[2] ^ cfg_mirror.key_second;
      run_rounds(12);
      res.tag_valid  = 1'b1;
      res.tag_first  = lane[3] ^ cfg_mirror.key_first;
      res.tag_second = lane[4] ^ cfg_mirror.key_second;
      msg_open = 1'b0;
    end else begin
      run_rounds(6);
      res.tag_valid  = 1'b0;
      res.tag_first  = '0;
      res.tag_second = '0;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    return burst_mode ? 0 : $urandom_range(0, 9);
  endfunction

  // Mostly random data, with the all-zero and all-one extremes mixed in.
  function automatic logic [WORD_W-1:0] pick_value();
    unique case ($urandom_range(0, 9))
      0:       return ZERO;
      1:       return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one word after a random gap, hold it until accepted, then
  // queue the predicted result. Park the config bus on the first step.
  task automatic send_word(input logic [WORD_W-1:0] pt, input logic first,
                           input logic last, input logic tag_clear);
    int          gap;
    cipher_out_t want;
    gap = pick_gap();
    psel    <= 1'b0;
    penable <= 1'b0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.plaintext_word <= pt;
    in_if.first_block    <= first;
    in_if.last_block     <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    want = encrypt_word(pt, first, last);
    if (tag_clear) begin
      want.tag_valid  = 1'b0;
      want.tag_first  = ZERO;
      want.tag_second = ZERO;
    end
    ciphertext_due.push_back(want);
    words_sent++;
  endtask

  // Drop valid and wait for every predicted word to come back.
  task automatic drain_words();
    in_if.valid <= 1'b0;
    while (ciphertext_due.size() != 0) @(posedge clk);
  endtask

  // Setup and access phase of a write, then a read back of the same register.
  // The bus is left in its last access phase; send_word parks it.
  task automatic write_reg(input reg_idx_t sel, input logic [WORD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    unique case (sel)
      REG_KEY_FIRST:    cfg_mirror.key_first    = value;
      REG_KEY_SECOND:   cfg_mirror.key_second   = value;
      REG_NONCE_FIRST:  cfg_mirror.nonce_first  = value;
      REG_NONCE_SECOND: cfg_mirror.nonce_second = value;
      REG_INIT_VECTOR:  cfg_mirror.init_vector  = value;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== value)
      note_mismatch("register readback", prdata, value);
  endtask

  // Result side: stall ready for a random count per word, then hold it high
  // until a word is taken.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
    end
  end

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (ciphertext_due.size() == 0) begin
        note_mismatch("word with none due", out_if.ciphertext_word, ZERO);
      end else begin
        want = ciphertext_due.pop_front();
        if (out_if.ciphertext_word !== want.ciphertext)
          note_mismatch("ciphertext_word", out_if.ciphertext_word, want.ciphertext);
        if (out_if.tag_valid !== want.tag_valid)
          note_mismatch("tag_valid", {{(WORD_W-1){1'b0}}, out_if.tag_valid},
                        {{(WORD_W-1){1'b0}}, want.tag_valid});
        if (out_if.tag_first !== want.tag_first)
          note_mismatch("tag_first", out_if.tag_first, want.tag_first);
        if (out_if.tag_second !== want.tag_second)
          note_mismatch("tag_second", out_if.tag_second, want.tag_second);
      end
    end
  end

  // Main sequence: reset, directed plan, then random phases of messages with
  // register changes between phases, often while a message is still open.
  initial begin
    int               phase_len;
    int               words_left;
    logic             msg_start;
    logic             first_bit;
    logic             last_bit;
    reg_idx_t         sel;
    logic [WORD_W-1:0] val;

    mismatch_count = 0;
    words_sent     = 0;
    burst_mode     = 1'b0;
    msg_open       = 1'b0;
    for (int i = 0; i < NUM_WORDS; i++) lane[i] = ZERO;
    cfg_mirror.key_first    = ZERO;
    cfg_mirror.key_second   = ZERO;
    cfg_mirror.nonce_first  = ZERO;
    cfg_mirror.nonce_second = ZERO;
    cfg_mirror.init_vector  = IV_RESET;

    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.plaintext_word <= ZERO;
    in_if.first_block    <= 1'b0;
    in_if.last_block     <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= ZERO;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan; idle the block before each register write.
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        drain_words();
        write_reg(PLAN[i].sel, PLAN[i].data);
      end else begin
        send_word(PLAN[i].data, PLAN[i].first, PLAN[i].last, PLAN[i].tag_clear);
      end
    end

    // Random phases. Messages run across phase boundaries so that register
    // writes land both between messages and inside open ones.
    words_left = 0;
    msg_start  = 1'b0;
    while (words_sent < PLAN_LEN + RANDOM_WORDS) begin
      drain_words();
      repeat ($urandom_range(0, 3)) begin
        sel = reg_idx_t'($urandom_range(0, 4));
        val = pick_value();
        // bring the standard IV back now and then
        if (sel == REG_INIT_VECTOR && $urandom_range(0, 1) == 0) val = IV_RESET;
        write_reg(sel, val);
      end
      burst_mode = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(4, 30);
      repeat (phase_len) begin
        if (words_left == 0) begin
          words_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(1, 8);
          msg_start  = 1'b1;
        end
        first_bit = msg_start;
        last_bit  = (words_left == 1);
        // noise: scramble the framing bits on about one word in ten
        if ($urandom_range(0, 9) == 0) begin
          first_bit = 1'($urandom_range(0, 1));
          last_bit  = 1'($urandom_range(0, 1));
        end
        send_word(pick_value(), first_bit, last_bit, 1'b0);
        words_left--;
        msg_start = 1'b0;
      end
    end

    burst_mode = 1'b0;
    drain_words();
    // Hold for SETTLE_CYCLES so a stray extra word would still be caught.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
